// ----- rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted list table package
// Item types, command codes and status codes shared by the front part, the
// back part and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned HELD_W  = 6;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SHOW   = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      value_type        item_value;
   } req_type;

   typedef struct packed {
      value_type         out_value;
      logic              is_last;
      logic [STAT_W-1:0] status;
      logic [HELD_W-1:0] entries_held;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/sorted_list_table_top.sv -----
// ----------------------------------------------------------------------------
// Sorted list table
// Insert: result registered at take, one insert a cycle while output is free.
// Delete: a pass over every held entry, then the result once output is free.
// Show: one result a cycle while output is free, by single-step rotation.
// Reset is synchronous and empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

// A bounded multiset of signed values kept in ascending order. The front
// part takes items through a two-entry queue, so an item can be accepted
// while the back part is still busy with an earlier one. Unused command codes
// are accepted and discarded there, giving no result.
//
// The back part keeps the entries in a row of cells. Insert compares the new
// value against every cell at once and shifts the upper part of the row by
// one place. Delete and show go through the row one entry a cycle (show only
// while the output register is free): the head cell is looked at, and then
// either rotated to the tail of the held entries or, for a delete match,
// dropped. After a full pass the row is once more in ascending order.
//
// Results leave through an output register, so the back part keeps working
// while the consumer stalls until that register is occupied and not popped.

module sorted_list_table_top #(
   parameter int unsigned DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire slt_pkg::req_type req_item,
   output logic                  empty,
   input  wire logic             pop,
   output slt_pkg::rsp_type      rsp_item
);
   import slt_pkg::*;

   logic    op_valid;
   logic    op_take;
   req_type op_item;

   // Front part: accept, classify and queue.
   slt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_take  (op_take)
   );

   // Back part: the cell row, its sequencer and the output register.
   slt_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_take  (op_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

`ifndef NO_ASSERTIONS
   // The back part must never take from an empty queue.
   assert property (@(posedge clock) disable iff (reset) op_take |-> op_valid)
      else $error("queue taken while empty");

   // A full queue always has an item waiting for the back part.
   assert property (@(posedge clock) disable iff (reset) full |-> op_valid)
      else $error("queue full but nothing offered to the back part");

   // Nothing is offered on the result side in the cycle after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> empty)
      else $error("result offered straight after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/slt_front.sv -----
// ----------------------------------------------------------------------------
// Sorted list table front part
// Accepts items, drops unused command codes and holds the rest in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire slt_pkg::req_type req_item,
   output logic                  op_valid,
   output slt_pkg::req_type      op_item,
   input  wire logic             op_take
);
   import slt_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;
   logic       known_cmd;
   logic       enqueue;

   // Only the three defined commands take a queue slot.
   assign known_cmd = (req_item.command == CMD_INSERT) ||
                      (req_item.command == CMD_DELETE) ||
                      (req_item.command == CMD_SHOW);

   assign full     = (level_ff == 2'd2);
   assign enqueue  = push && !full && known_cmd;
   assign op_valid = (level_ff != 2'd0);
   assign op_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enqueue ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = op_take ? !rd_ptr_ff : rd_ptr_ff;
      level_in  = 2'(level_ff + {1'b0, enqueue} - {1'b0, op_take});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enqueue) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/slt_back.sv -----
// ----------------------------------------------------------------------------
// Sorted list table back part
// A row of entry cells with a sequencer: insert by a parallel compare and
// shift, delete and show by rotating the row one entry a cycle (show only
// while the output register is free), results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_back #(
   parameter int unsigned DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_valid,
   input  wire slt_pkg::req_type op_item,
   output logic                  op_take,
   output logic                  empty,
   input  wire logic             pop,
   output slt_pkg::rsp_type      rsp_item
);
   import slt_pkg::*;

   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_DELETE   = 2'd1;
   localparam logic [1:0] S_DEL_DONE = 2'd2;
   localparam logic [1:0] S_SHOW     = 2'd3;

   value_type       cell_ff [DEPTH];
   value_type       cell_in [DEPTH];
   value_type       ins_cell [DEPTH];
   value_type       rot_cell [DEPTH];
   value_type       shl_cell [DEPTH];
   logic [DEPTH-1:0] below;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] steps_ff, steps_in;
   logic [1:0]      state_ff, state_in;
   value_type       val_ff, val_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_item_ff, out_item_in;
   logic            out_free;
   logic            emit;
   rsp_type         emit_item;

   assign out_free = !out_valid_ff || pop;
   assign empty    = !out_valid_ff;
   assign rsp_item = out_item_ff;

   // Cell-wise next values for the three row moves.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         below[i] = (CntW'(i) < cnt_ff) && (cell_ff[i] < op_item.item_value);
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (below[i]) begin
            ins_cell[i] = cell_ff[i];
         end else if (i == 0) begin
            ins_cell[i] = op_item.item_value;
         end else if (below[(i == 0) ? 0 : i - 1]) begin
            ins_cell[i] = op_item.item_value;
         end else begin
            ins_cell[i] = cell_ff[(i == 0) ? 0 : i - 1];
         end
         shl_cell[i] = cell_ff[(i == DEPTH - 1) ? 0 : i + 1];
         rot_cell[i] = (CntW'(i) == CntW'(cnt_ff - 1'b1)) ? cell_ff[0] : shl_cell[i];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      steps_in  = steps_ff;
      val_in    = val_ff;
      cell_in   = cell_ff;
      op_take   = 1'b0;
      emit      = 1'b0;
      emit_item = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && out_free) begin
               op_take = 1'b1;
               unique case (op_item.command)
                  CMD_INSERT: begin
                     emit                = 1'b1;
                     emit_item.out_value = op_item.item_value;
                     emit_item.is_last   = 1'b1;
                     if (cnt_ff == DepthCnt) begin
                        emit_item.status       = STATUS_FULL;
                        emit_item.entries_held = HELD_W'(cnt_ff);
                     end else begin
                        cell_in                = ins_cell;
                        cnt_in                 = CntW'(cnt_ff + 1'b1);
                        emit_item.status       = STATUS_OK;
                        emit_item.entries_held = HELD_W'(cnt_in);
                     end
                  end
                  CMD_DELETE: begin
                     if (cnt_ff == '0) begin
                        emit                   = 1'b1;
                        emit_item.out_value    = op_item.item_value;
                        emit_item.is_last      = 1'b1;
                        emit_item.status       = STATUS_EMPTY;
                        emit_item.entries_held = '0;
                     end else begin
                        state_in = S_DELETE;
                        steps_in = cnt_ff;
                        val_in   = op_item.item_value;
                     end
                  end
                  CMD_SHOW: begin
                     if (cnt_ff == '0) begin
                        emit                   = 1'b1;
                        emit_item.out_value    = '0;
                        emit_item.is_last      = 1'b1;
                        emit_item.status       = STATUS_EMPTY;
                        emit_item.entries_held = '0;
                     end else begin
                        state_in = S_SHOW;
                        steps_in = cnt_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DELETE: begin
            // The head entry is either dropped or rotated to the tail, so
            // after one pass the survivors are back in ascending order.
            if (cell_ff[0] == val_ff) begin
               cell_in = shl_cell;
               cnt_in  = CntW'(cnt_ff - 1'b1);
            end else begin
               cell_in = rot_cell;
            end
            steps_in = CntW'(steps_ff - 1'b1);
            if (steps_ff == CntW'(1)) begin
               state_in = S_DEL_DONE;
            end
         end
         S_DEL_DONE: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_item.out_value    = val_ff;
               emit_item.is_last      = 1'b1;
               emit_item.status       = STATUS_OK;
               emit_item.entries_held = HELD_W'(cnt_ff);
               state_in               = S_IDLE;
            end
         end
         S_SHOW: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_item.out_value    = cell_ff[0];
               emit_item.is_last      = (steps_ff == CntW'(1));
               emit_item.status       = STATUS_OK;
               emit_item.entries_held = HELD_W'(cnt_ff);
               cell_in                = rot_cell;
               steps_in               = CntW'(steps_ff - 1'b1);
               if (steps_ff == CntW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = emit ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
      out_item_in  = emit ? emit_item : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         steps_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         steps_ff     <= steps_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      val_ff      <= val_in;
      out_item_ff <= out_item_in;
   end

endmodule

`default_nettype wire
